// File: rtl/core/ispa_pkg.sv
package ispa_pkg;

	// Default pool geometry
	localparam int MAX_SLOTS_DEF  = 64;
	localparam int NEST_DEPTH_DEF = 64;

	// Pool layout: wrapper code, then one table entry per slot, then the stacks
	localparam int ENTRY_BYTES   = 8;
	localparam int WRAPPER_BYTES = 32'h20;

	// Overflow counter ceiling
	localparam logic [7:0] OVF_MAX = 8'hFF;

	// Configuration word widths
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;

	// Register reset values
	localparam logic [6:0] SLOT_COUNT_RST = 7'd9;
	localparam logic [9:0] SLOT_BYTES_RST = 10'd128;

	// Request codes
	localparam logic REQ_ENTER = 1'b0;
	localparam logic REQ_LEAVE = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_ENABLE     = 8'd0,
		CFG_SLOT_COUNT = 8'd1,
		CFG_SLOT_BYTES = 8'd2,
		CFG_POOL_SEG   = 8'd3
	} ispa_cfg_idx_t;

	typedef enum logic [1:0] {
		ACT_NONE    = 2'd0,
		ACT_SWITCH  = 2'd1,
		ACT_RESTORE = 2'd2
	} ispa_action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_POP,
		ST_RESTORE,
		ST_FIN
	} ispa_state_t;

	// Commands from the sequencer to the slot search unit
	typedef struct packed {
		logic clear;
		logic start;
		logic set;
		logic free;
	} ispa_srch_cmd_t;

	// Status back from the slot search unit
	typedef struct packed {
		logic done;
		logic found;
	} ispa_srch_sts_t;

endpackage

// File: rtl/core/ispa_ram.sv
module ispa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/ispa_slot_search.sv
module ispa_slot_search #(
	parameter int MAX_SLOTS = ispa_pkg::MAX_SLOTS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  ispa_pkg::ispa_srch_cmd_t                      cmd,
	input  logic [(MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1)-1:0] start_idx,
	input  logic [$clog2(MAX_SLOTS + 1)-1:0]              n_eff,
	input  logic [(MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1)-1:0] mark_idx,
	output ispa_pkg::ispa_srch_sts_t                      sts,
	output logic [(MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1)-1:0] idx
);

	localparam int SW = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
	localparam int CW = $clog2(MAX_SLOTS + 1);

	logic [MAX_SLOTS-1:0] busy_q;
	logic                 active_q;
	logic                 done_q;
	logic                 found_q;
	logic [SW-1:0]        cur_q;
	logic [CW-1:0]        cnt_q;
	logic [SW-1:0]        idx_q;
	logic [SW-1:0]        cur_dec;

	// Step downward, wrap from zero to the top slot
	assign cur_dec = (cur_q == '0) ? SW'(n_eff - CW'(1)) : cur_q - SW'(1);

	// Walk one slot per cycle until a free one turns up or all were seen
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= '0;
			active_q <= 1'b0;
			done_q   <= 1'b0;
			found_q  <= 1'b0;
			cur_q    <= '0;
			cnt_q    <= '0;
			idx_q    <= '0;
		end else if (cmd.clear) begin
			busy_q   <= '0;
			active_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				active_q <= 1'b1;
				cur_q    <= start_idx;
				cnt_q    <= n_eff;
			end else if (active_q) begin
				if (!busy_q[cur_q]) begin
					done_q   <= 1'b1;
					found_q  <= 1'b1;
					idx_q    <= cur_q;
					active_q <= 1'b0;
				end else if (cnt_q == CW'(1)) begin
					done_q   <= 1'b1;
					found_q  <= 1'b0;
					active_q <= 1'b0;
				end else begin
					cur_q <= cur_dec;
					cnt_q <= cnt_q - CW'(1);
				end
			end
			// Mark a slot taken or released
			if (cmd.set) begin
				busy_q[mark_idx] <= 1'b1;
			end
			if (cmd.free) begin
				busy_q[mark_idx] <= 1'b0;
			end
		end
	end

	assign sts.done  = done_q;
	assign sts.found = found_q;
	assign idx       = idx_q;

endmodule

// File: rtl/core/interrupt_stack_pool_allocator.sv
// Interrupt stack pool allocator.
// Input channel (in_valid / in_stall): one word per interrupt event, req_type
// 0 for enter with the interrupted cur_ss / cur_sp, 1 for leave. Output
// channel (out_valid / out_stall): one result word per event with action,
// out_ss, out_sp, slot_index and pool_exhausted.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 enable,
// 1 slot_count, 2 slot_bytes, 3 pool_segment. Any write to those indexes
// empties the pool; other indexes are ignored. Write only while idle.
// A pass-through or counted event goes straight to the finish state; a leave
// reads the nesting stack in a pop state and, for a valid entry, restores in
// a further state; an enter runs the free-slot search, which checks one slot
// per cycle. One event is in work at a time; the next is taken in the cycle
// after its result is registered, even if that result is still stalled.
// Saved SS:SP and the nesting stack sit in single-port-pair RAMs with a
// registered read port; busy bits are flip-flops.
// Reset clears the pool, the nesting stack and the registers to their
// defaults; no clearing pass is needed. A stalled result holds in the output
// register and blocks only the completion of the following event.
module interrupt_stack_pool_allocator #(
	parameter int MAX_SLOTS  = ispa_pkg::MAX_SLOTS_DEF,
	parameter int NEST_DEPTH = ispa_pkg::NEST_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             req_type,
	input  logic [15:0]                      cur_ss,
	input  logic [15:0]                      cur_sp,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       action,
	output logic [15:0]                      out_ss,
	output logic [15:0]                      out_sp,
	output logic [5:0]                       slot_index,
	output logic                             pool_exhausted,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ispa_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ispa_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int SW = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;
	localparam int CW = $clog2(MAX_SLOTS + 1);
	localparam int AW = NEST_DEPTH > 1 ? $clog2(NEST_DEPTH) : 1;
	localparam int DW = $clog2(NEST_DEPTH + 1);

	// Configuration registers
	logic        enable_q;
	logic [6:0]  slot_count_q;
	logic [9:0]  slot_bytes_q;
	logic [15:0] pool_seg_q;

	// Pool control state
	ispa_pkg::ispa_state_t state_q, state_d;
	logic [DW-1:0] depth_q;
	logic [7:0]    ovf_q;
	logic [SW-1:0] start_q;
	logic [SW-1:0] pop_idx_q;
	logic [15:0]   ss_in_q;
	logic [15:0]   sp_in_q;

	// Result under construction
	ispa_pkg::ispa_action_t res_action_q;
	logic [15:0]   res_ss_q;
	logic [15:0]   res_sp_q;
	logic [SW-1:0] res_slot_q;
	logic          res_exh_q;

	// Output register
	logic                   out_valid_q;
	ispa_pkg::ispa_action_t out_action_q;
	logic [15:0]            out_ss_q;
	logic [15:0]            out_sp_q;
	logic [SW-1:0]          out_slot_q;
	logic                   out_exh_q;

	logic          accept;
	logic          cfg_clear;
	logic          nest_full;
	logic          out_load;
	logic [CW-1:0] n_eff;
	logic [SW-1:0] n_top;
	logic [SW-1:0] start_cl;
	logic [SW:0]   idx_p1;
	logic [SW+10:0] prod;
	logic [31:0]   top_full;

	ispa_pkg::ispa_srch_cmd_t srch_cmd;
	ispa_pkg::ispa_srch_sts_t srch_sts;
	logic [SW-1:0] srch_idx;
	logic [SW-1:0] mark_idx;

	logic          nest_we;
	logic [AW-1:0] nest_waddr;
	logic [SW:0]   nest_wdata;
	logic [AW-1:0] nest_raddr;
	logic [SW:0]   nest_rdata;
	logic          save_we;
	logic [31:0]   save_rdata;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ispa_pkg::ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_load  = (state_q == ispa_pkg::ST_FIN) && (!out_valid_q || !out_stall);

	// Clamp the slot count into one .. MAX_SLOTS
	always_comb begin
		if (slot_count_q == 7'd0) begin
			n_eff = CW'(1);
		end else if (32'(slot_count_q) > MAX_SLOTS) begin
			n_eff = CW'(MAX_SLOTS);
		end else begin
			n_eff = CW'(slot_count_q);
		end
	end

	assign n_top     = SW'(n_eff - CW'(1));
	assign start_cl  = (32'(start_q) >= 32'(n_eff)) ? n_top : start_q;
	assign nest_full = 32'(depth_q) >= NEST_DEPTH;

	// Stack top of the found slot
	assign idx_p1   = {1'b0, srch_idx} + (SW+1)'(1);
	assign prod     = {10'd0, idx_p1} * {(SW+1)'(0), slot_bytes_q};
	assign top_full = 32'(ispa_pkg::WRAPPER_BYTES) + (32'(n_eff) << 3) + 32'(prod) - 32'd2;

	// Only listed register indexes empty the pool
	always_comb begin
		cfg_clear = 1'b0;
		if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ispa_pkg::CFG_ENABLE,
				ispa_pkg::CFG_SLOT_COUNT,
				ispa_pkg::CFG_SLOT_BYTES,
				ispa_pkg::CFG_POOL_SEG: cfg_clear = 1'b1;
				default:                cfg_clear = 1'b0;
			endcase
		end
	end

	// Memory addressing
	assign nest_waddr = AW'(depth_q);
	assign nest_wdata = srch_sts.found ? {1'b1, srch_idx} : '0;
	assign nest_raddr = AW'(depth_q - DW'(1));
	assign mark_idx   = (state_q == ispa_pkg::ST_RESTORE) ? pop_idx_q : srch_idx;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ispa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and strobes
	always_comb begin
		state_d        = state_q;
		srch_cmd       = '0;
		srch_cmd.clear = cfg_clear;
		nest_we        = 1'b0;
		save_we        = 1'b0;
		case (state_q)
			ispa_pkg::ST_IDLE: begin
				if (accept) begin
					if (!enable_q) begin
						state_d = ispa_pkg::ST_FIN;
					end else if (req_type == ispa_pkg::REQ_ENTER) begin
						if (nest_full) begin
							state_d = ispa_pkg::ST_FIN;
						end else begin
							srch_cmd.start = 1'b1;
							state_d        = ispa_pkg::ST_SEARCH;
						end
					end else if (ovf_q != 8'd0 || depth_q == '0) begin
						state_d = ispa_pkg::ST_FIN;
					end else begin
						state_d = ispa_pkg::ST_POP;
					end
				end
			end
			ispa_pkg::ST_SEARCH: begin
				if (srch_sts.done) begin
					nest_we      = 1'b1;
					save_we      = srch_sts.found;
					srch_cmd.set = srch_sts.found;
					state_d      = ispa_pkg::ST_FIN;
				end
			end
			ispa_pkg::ST_POP: begin
				state_d = nest_rdata[SW] ? ispa_pkg::ST_RESTORE : ispa_pkg::ST_FIN;
			end
			ispa_pkg::ST_RESTORE: begin
				srch_cmd.free = 1'b1;
				state_d       = ispa_pkg::ST_FIN;
			end
			ispa_pkg::ST_FIN: begin
				if (out_load) begin
					state_d = ispa_pkg::ST_IDLE;
				end
			end
			default: state_d = ispa_pkg::ST_IDLE;
		endcase
	end

	// Configuration, pool counters and result assembly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= 1'b0;
			slot_count_q <= ispa_pkg::SLOT_COUNT_RST;
			slot_bytes_q <= ispa_pkg::SLOT_BYTES_RST;
			pool_seg_q   <= '0;
			depth_q      <= '0;
			ovf_q        <= '0;
			start_q      <= '1;
			pop_idx_q    <= '0;
			ss_in_q      <= '0;
			sp_in_q      <= '0;
			res_action_q <= ispa_pkg::ACT_NONE;
			res_ss_q     <= '0;
			res_sp_q     <= '0;
			res_slot_q   <= '0;
			res_exh_q    <= 1'b0;
		end else begin
			case (state_q)
				ispa_pkg::ST_IDLE: begin
					if (accept) begin
						ss_in_q      <= cur_ss;
						sp_in_q      <= cur_sp;
						res_action_q <= ispa_pkg::ACT_NONE;
						res_ss_q     <= cur_ss;
						res_sp_q     <= cur_sp;
						res_slot_q   <= '0;
						res_exh_q    <= 1'b0;
						if (enable_q) begin
							if (req_type == ispa_pkg::REQ_ENTER) begin
								if (nest_full && ovf_q != ispa_pkg::OVF_MAX) begin
									ovf_q <= ovf_q + 8'd1;
								end
							end else if (ovf_q != 8'd0) begin
								ovf_q <= ovf_q - 8'd1;
							end else if (depth_q != '0) begin
								depth_q <= depth_q - DW'(1);
							end
						end
					end
				end
				ispa_pkg::ST_SEARCH: begin
					if (srch_sts.done) begin
						depth_q <= depth_q + DW'(1);
						if (srch_sts.found) begin
							start_q      <= (srch_idx == '0) ? n_top : srch_idx - SW'(1);
							res_action_q <= ispa_pkg::ACT_SWITCH;
							res_ss_q     <= pool_seg_q;
							res_sp_q     <= top_full[15:0];
							res_slot_q   <= srch_idx;
						end else begin
							res_exh_q <= 1'b1;
						end
					end
				end
				ispa_pkg::ST_POP: begin
					pop_idx_q <= nest_rdata[SW-1:0];
				end
				ispa_pkg::ST_RESTORE: begin
					res_action_q <= ispa_pkg::ACT_RESTORE;
					res_ss_q     <= save_rdata[31:16];
					res_sp_q     <= save_rdata[15:0];
					res_slot_q   <= pop_idx_q;
					start_q      <= (32'(pop_idx_q) < 32'(n_eff)) ? pop_idx_q : n_top;
				end
				default: begin
				end
			endcase
			// Register write, pool emptied
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ispa_pkg::CFG_ENABLE:     enable_q     <= cfg_data[0];
					ispa_pkg::CFG_SLOT_COUNT: slot_count_q <= cfg_data[6:0];
					ispa_pkg::CFG_SLOT_BYTES: slot_bytes_q <= cfg_data[9:0];
					ispa_pkg::CFG_POOL_SEG:   pool_seg_q   <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cfg_clear) begin
				depth_q <= '0;
				ovf_q   <= '0;
				start_q <= '1;
			end
		end
	end

	// Output register: load on finish, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_action_q <= ispa_pkg::ACT_NONE;
			out_ss_q     <= '0;
			out_sp_q     <= '0;
			out_slot_q   <= '0;
			out_exh_q    <= 1'b0;
		end else if (out_load) begin
			out_valid_q  <= 1'b1;
			out_action_q <= res_action_q;
			out_ss_q     <= res_ss_q;
			out_sp_q     <= res_sp_q;
			out_slot_q   <= res_slot_q;
			out_exh_q    <= res_exh_q;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign action         = out_action_q;
	assign out_ss         = out_ss_q;
	assign out_sp         = out_sp_q;
	assign slot_index     = 6'(out_slot_q);
	assign pool_exhausted = out_exh_q;

	ispa_slot_search #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (srch_cmd),
		.start_idx(start_cl),
		.n_eff    (n_eff),
		.mark_idx (mark_idx),
		.sts      (srch_sts),
		.idx      (srch_idx)
	);

	// Nesting stack: valid mark and slot number per level
	ispa_ram #(
		.WIDTH(SW + 1),
		.DEPTH(NEST_DEPTH)
	) u_nest_ram (
		.clk  (clk),
		.we   (nest_we),
		.waddr(nest_waddr),
		.wdata(nest_wdata),
		.raddr(nest_raddr),
		.rdata(nest_rdata)
	);

	// Saved SS:SP per slot
	ispa_ram #(
		.WIDTH(32),
		.DEPTH(MAX_SLOTS)
	) u_save_ram (
		.clk  (clk),
		.we   (save_we),
		.waddr(srch_idx),
		.wdata({ss_in_q, sp_in_q}),
		.raddr(nest_rdata[SW-1:0]),
		.rdata(save_rdata)
	);

	// Search results arrive only while the sequencer waits for them
	assert property (@(posedge clk) disable iff (!arst_n)
		srch_sts.done |-> state_q == ispa_pkg::ST_SEARCH)
		else $error("search done outside search state");

	// A push never runs past the nesting stack
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ispa_pkg::ST_SEARCH |-> 32'(depth_q) < NEST_DEPTH)
		else $error("push into full nesting stack");

	// Overflow is counted only on top of a full nesting stack
	assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q != 8'd0 |-> 32'(depth_q) == NEST_DEPTH)
		else $error("overflow count with nesting stack not full");

	// A new result comes only from the finish state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ispa_pkg::ST_FIN)
		else $error("result raised outside finish state");

endmodule

// File: tb/sv/interrupt_stack_pool_allocator_tb.sv
module interrupt_stack_pool_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT   = 1_000_000;
	localparam int unsigned SETTLE_CYCLES = 80;
	localparam int unsigned RANDOM_EVENTS = 210;
	// register index outside the map; the block must ignore it
	localparam logic [ispa_pkg::CFG_INDEX_W-1:0] CFG_IDX_SPARE = 8'hA5;

	typedef struct packed {
		ispa_pkg::ispa_action_t act;
		logic [15:0]            ss;
		logic [15:0]            sp;
		logic [5:0]             slot;
		logic                   exhausted;
	} stack_answer_t;

	logic                             clk            = 1'b0;
	logic                             arst_n         = 1'b0;
	logic                             in_valid       = 1'b0;
	logic                             in_stall;
	logic                             req_type       = ispa_pkg::REQ_ENTER;
	logic [15:0]                      cur_ss         = '0;
	logic [15:0]                      cur_sp         = '0;
	logic                             out_valid;
	logic                             out_stall      = 1'b0;
	logic [1:0]                       action;
	logic [15:0]                      out_ss;
	logic [15:0]                      out_sp;
	logic [5:0]                       slot_index;
	logic                             pool_exhausted;
	logic                             cfg_valid      = 1'b0;
	logic                             cfg_ready;
	logic [ispa_pkg::CFG_INDEX_W-1:0] cfg_index      = '0;
	logic [ispa_pkg::CFG_DATA_W-1:0]  cfg_data       = '0;

	// predicted register copies
	logic        reg_enable;
	logic [6:0]  reg_slot_count;
	logic [9:0]  reg_slot_bytes;
	logic [15:0] reg_pool_seg;

	// predicted pool state
	bit          slot_busy [ispa_pkg::MAX_SLOTS_DEF];
	logic [15:0] stash_ss  [ispa_pkg::MAX_SLOTS_DEF];
	logic [15:0] stash_sp  [ispa_pkg::MAX_SLOTS_DEF];
	bit          nest_used [ispa_pkg::NEST_DEPTH_DEF];
	int unsigned nest_slot [ispa_pkg::NEST_DEPTH_DEF];
	int unsigned nest_level;
	int unsigned overflow_level;
	int unsigned search_ptr;

	stack_answer_t switch_answers[$];
	int unsigned   mismatches  = 0;
	int unsigned   cycle_count = 0;
	int unsigned   send_idle_pct = 0;
	int unsigned   stall_pct     = 0;

	interrupt_stack_pool_allocator DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.cur_ss         (cur_ss),
		.cur_sp         (cur_sp),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.action         (action),
		.out_ss         (out_ss),
		.out_sp         (out_sp),
		.slot_index     (slot_index),
		.pool_exhausted (pool_exhausted),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #6 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic int unsigned live_slots();
		if (reg_slot_count == 0)
			return 1;
		if (reg_slot_count > ispa_pkg::MAX_SLOTS_DEF)
			return ispa_pkg::MAX_SLOTS_DEF;
		return 32'(reg_slot_count);
	endfunction

	// Top of a slot's private stack, wrapping at 64K
	function automatic logic [15:0] slot_stack_top(input int unsigned idx, input int unsigned n);
		int unsigned v;
		v = ispa_pkg::WRAPPER_BYTES + n * ispa_pkg::ENTRY_BYTES + (idx + 1) * reg_slot_bytes - 2;
		return v[15:0];
	endfunction

	// Free every slot and empty the nesting stack
	function automatic void clear_pool();
		for (int i = 0; i < ispa_pkg::MAX_SLOTS_DEF; i++)
			slot_busy[i] = 1'b0;
		for (int i = 0; i < ispa_pkg::NEST_DEPTH_DEF; i++) begin
			nest_used[i] = 1'b0;
			nest_slot[i] = 0;
		end
		nest_level     = 0;
		overflow_level = 0;
		search_ptr     = live_slots() - 1;
	endfunction

	function automatic void reset_pool_model();
		reg_enable     = 1'b0;
		reg_slot_count = ispa_pkg::SLOT_COUNT_RST;
		reg_slot_bytes = ispa_pkg::SLOT_BYTES_RST;
		reg_pool_seg   = '0;
		clear_pool();
	endfunction

	// Mirror one register write; known indexes also clear the pool
	function automatic void apply_register(input logic [ispa_pkg::CFG_INDEX_W-1:0] idx,
			input logic [ispa_pkg::CFG_DATA_W-1:0] val);
		bit hit;
		hit = 1'b1;
		case (idx)
			ispa_pkg::CFG_ENABLE:     reg_enable     = val[0];
			ispa_pkg::CFG_SLOT_COUNT: reg_slot_count = val[6:0];
			ispa_pkg::CFG_SLOT_BYTES: reg_slot_bytes = val[9:0];
			ispa_pkg::CFG_POOL_SEG:   reg_pool_seg   = val;
			default:                  hit            = 1'b0;
		endcase
		if (hit)
			clear_pool();
	endfunction

	// Advance the pool model by one event and return the answer it gives
	function automatic stack_answer_t predict_stack_switch(input logic kind,
			input logic [15:0] ss, input logic [15:0] sp);
		stack_answer_t r;
		int unsigned   n;
		int unsigned   idx;
		bit            found;
		r.act       = ispa_pkg::ACT_NONE;
		r.ss        = ss;
		r.sp        = sp;
		r.slot      = '0;
		r.exhausted = 1'b0;
		n           = live_slots();
		idx         = 0;
		found       = 1'b0;
		if (search_ptr >= n)
			search_ptr = n - 1;
		if (reg_enable) begin
			if (kind == ispa_pkg::REQ_ENTER) begin
				if (nest_level >= ispa_pkg::NEST_DEPTH_DEF) begin
					if (overflow_level < ispa_pkg::OVF_MAX)
						overflow_level++;
				end else begin
					// walk down from the search pointer, wrapping at zero
					for (int unsigned i = 0; i < n && !found; i++) begin
						idx   = (search_ptr + n - i) % n;
						found = !slot_busy[idx];
					end
					if (found) begin
						slot_busy[idx]        = 1'b1;
						search_ptr            = (idx == 0) ? n - 1 : idx - 1;
						stash_ss[idx]         = ss;
						stash_sp[idx]         = sp;
						nest_used[nest_level] = 1'b1;
						nest_slot[nest_level] = idx;
						r.act                 = ispa_pkg::ACT_SWITCH;
						r.ss                  = reg_pool_seg;
						r.sp                  = slot_stack_top(idx, n);
						r.slot                = idx[5:0];
					end else begin
						nest_used[nest_level] = 1'b0;
						nest_slot[nest_level] = 0;
						r.exhausted           = 1'b1;
					end
					nest_level++;
				end
			end else if (overflow_level > 0) begin
				overflow_level--;
			end else if (nest_level > 0) begin
				nest_level--;
				if (nest_used[nest_level]) begin
					idx            = nest_slot[nest_level];
					r.act          = ispa_pkg::ACT_RESTORE;
					r.ss           = stash_ss[idx];
					r.sp           = stash_sp[idx];
					r.slot         = idx[5:0];
					slot_busy[idx] = 1'b0;
					search_ptr     = (idx < n) ? idx : n - 1;
				end
				nest_used[nest_level] = 1'b0;
				nest_slot[nest_level] = 0;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		mismatches++;
		$display("%0t ns: %s got %h expected %h", $time, what, got, want);
	endtask

	// Check each accepted result word, then pick the next stall
	always @(posedge clk) begin : check_answers
		stack_answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (switch_answers.size() == 0) begin
				report_mismatch("result word with no event pending", 16'(action), 16'd0);
			end else begin
				want = switch_answers.pop_front();
				if (action !== want.act)
					report_mismatch("action", 16'(action), 16'(want.act));
				if (out_ss !== want.ss)
					report_mismatch("out_ss", out_ss, want.ss);
				if (out_sp !== want.sp)
					report_mismatch("out_sp", out_sp, want.sp);
				if (slot_index !== want.slot)
					report_mismatch("slot_index", 16'(slot_index), 16'(want.slot));
				if (pool_exhausted !== want.exhausted)
					report_mismatch("pool_exhausted", 16'(pool_exhausted),
						16'(want.exhausted));
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
		send_idle_pct = send_pct;
		stall_pct     = recv_pct;
	endtask

	// Send one event word; valid stays high so a following word can go back to back
	task automatic send_event(input logic kind, input logic [15:0] ss, input logic [15:0] sp);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		cur_ss   <= ss;
		cur_sp   <= sp;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		switch_answers.push_back(predict_stack_switch(kind, ss, sp));
	endtask

	// Hold the sender until every result word is back
	task automatic drain_answers();
		in_valid <= 1'b0;
		while (switch_answers.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Write one register; call only while the block is idle
	task automatic write_reg(input logic [ispa_pkg::CFG_INDEX_W-1:0] idx,
			input logic [ispa_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_register(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] rand_word();
		case ($urandom_range(9))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_slot_count();
		case ($urandom_range(9))
			0:       return 16'd1;
			1:       return 16'd2;
			2:       return 16'd64;
			3:       return 16'd0;
			4:       return 16'($urandom_range(65, 127));
			5:       return 16'($urandom_range(13, 63));
			default: return 16'($urandom_range(3, 12));
		endcase
	endfunction

	function automatic logic [15:0] pick_slot_bytes();
		case ($urandom_range(7))
			0:       return 16'd32;
			1:       return 16'd512;
			2:       return 16'd1023;
			3:       return 16'($urandom_range(0, 31));
			4:       return 16'($urandom_range(513, 1023));
			default: return 16'($urandom_range(32, 512));
		endcase
	endfunction

	// Disabled block passes both kinds of event through
	task automatic test_disabled_passthrough();
		send_event(ispa_pkg::REQ_ENTER, 16'h1234, 16'h5678);
		send_event(ispa_pkg::REQ_LEAVE, 16'hFFFF, 16'h0000);
	endtask

	// Nest and unwind with the current geometry, then leave with nothing nested
	task automatic test_nesting_order();
		drain_answers();
		write_reg(ispa_pkg::CFG_ENABLE, 16'd1);
		send_event(ispa_pkg::REQ_ENTER, 16'hFFFF, 16'h0000);
		send_event(ispa_pkg::REQ_ENTER, 16'h0000, 16'hFFFF);
		send_event(ispa_pkg::REQ_ENTER, 16'hA5A5, 16'h5A5A);
		send_event(ispa_pkg::REQ_LEAVE, 16'h0000, 16'h0000);
		send_event(ispa_pkg::REQ_LEAVE, 16'h0000, 16'h0000);
		send_event(ispa_pkg::REQ_ENTER, 16'h1357, 16'h2468);
		send_event(ispa_pkg::REQ_LEAVE, 16'h0000, 16'h0000);
		send_event(ispa_pkg::REQ_LEAVE, 16'h0000, 16'h0000);
		send_event(ispa_pkg::REQ_LEAVE, 16'hFFFF, 16'hFFFF);
	endtask

	// Two slots: third enter finds the pool full and pushes an empty entry
	task automatic test_pool_exhaustion();
		drain_answers();
		write_reg(ispa_pkg::CFG_SLOT_COUNT, 16'd2);
		write_reg(ispa_pkg::CFG_POOL_SEG, 16'hFFFF);
		write_reg(ispa_pkg::CFG_SLOT_BYTES, 16'd512);
		repeat (3)
			send_event(ispa_pkg::REQ_ENTER, rand_word(), rand_word());
		repeat (3)
			send_event(ispa_pkg::REQ_LEAVE, rand_word(), rand_word());
	endtask

	// Slot count and size beyond their ranges; writes in the middle of a nest
	task automatic test_size_extremes();
		drain_answers();
		write_reg(ispa_pkg::CFG_SLOT_COUNT, 16'd0);
		write_reg(ispa_pkg::CFG_SLOT_BYTES, 16'd1023);
		send_event(ispa_pkg::REQ_ENTER, 16'hBEEF, 16'hCAFE);
		send_event(ispa_pkg::REQ_LEAVE, 16'h0000, 16'h0000);
		drain_answers();
		write_reg(ispa_pkg::CFG_SLOT_COUNT, 16'd127);
		write_reg(ispa_pkg::CFG_SLOT_BYTES, 16'd32);
		send_event(ispa_pkg::REQ_ENTER, 16'h8000, 16'h0001);
		send_event(ispa_pkg::REQ_ENTER, 16'h0001, 16'h8000);
		// unmapped index must leave the nest alone
		drain_answers();
		write_reg(CFG_IDX_SPARE, 16'hFFFF);
		send_event(ispa_pkg::REQ_LEAVE, 16'h0000, 16'h0000);
		// a real write empties the pool, so the next leave restores nothing
		drain_answers();
		write_reg(ispa_pkg::CFG_POOL_SEG, 16'h0000);
		send_event(ispa_pkg::REQ_LEAVE, 16'h0000, 16'h0000);
		send_event(ispa_pkg::REQ_ENTER, 16'h7FFF, 16'hFFFE);
		drain_answers();
		write_reg(ispa_pkg::CFG_ENABLE, 16'd0);
		send_event(ispa_pkg::REQ_LEAVE, 16'h0000, 16'h0000);
	endtask

	// Fill the nesting stack, saturate the overflow count, then unwind it all
	task automatic test_overflow_saturation();
		drain_answers();
		write_reg(ispa_pkg::CFG_ENABLE, 16'd1);
		write_reg(ispa_pkg::CFG_SLOT_COUNT, 16'd3);
		repeat (ispa_pkg::NEST_DEPTH_DEF + ispa_pkg::OVF_MAX + 5)
			send_event(ispa_pkg::REQ_ENTER, rand_word(), rand_word());
		repeat (ispa_pkg::NEST_DEPTH_DEF + ispa_pkg::OVF_MAX + 8)
			send_event(ispa_pkg::REQ_LEAVE, rand_word(), rand_word());
	endtask

	// Mostly well-formed nesting with random content, some noise and drains
	task automatic test_random_traffic(input int unsigned total);
		int unsigned sent;
		int unsigned seg;
		int unsigned seg_len;
		int unsigned target;
		int unsigned open_level;
		logic        kind;
		sent = 0;
		seg  = 0;
		while (sent < total) begin
			case (seg % 4)
				0:       set_idling(0, 0);
				1:       set_idling(75, 0);
				2:       set_idling(0, 75);
				default: set_idling(29, 29);
			endcase
			drain_answers();
			write_reg(ispa_pkg::CFG_ENABLE, ($urandom_range(9) != 0) ? 16'd1 : 16'd0);
			write_reg(ispa_pkg::CFG_SLOT_COUNT, pick_slot_count());
			write_reg(ispa_pkg::CFG_SLOT_BYTES, pick_slot_bytes());
			write_reg(ispa_pkg::CFG_POOL_SEG, rand_word());
			target     = $urandom_range(1, 14);
			seg_len    = $urandom_range(24, 40);
			open_level = 0;
			for (int unsigned k = 0; k < seg_len; k++) begin
				if ($urandom_range(99) < 8)
					kind = 1'($urandom_range(1));
				else if ($urandom_range(99) < ((open_level < target) ? 70 : 25))
					kind = ispa_pkg::REQ_ENTER;
				else
					kind = ispa_pkg::REQ_LEAVE;
				if (kind == ispa_pkg::REQ_ENTER)
					open_level++;
				else if (open_level > 0)
					open_level--;
				if ($urandom_range(99) < 2)
					drain_answers();
				send_event(kind, rand_word(), rand_word());
			end
			sent += seg_len;
			seg++;
		end
	endtask

	initial begin
		reset_pool_model();
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_disabled_passthrough();
		test_nesting_order();
		test_pool_exhaustion();
		test_size_extremes();
		set_idling(0, 0);
		test_overflow_saturation();
		set_idling(29, 29);
		test_nesting_order();
		test_random_traffic(RANDOM_EVENTS);

		drain_answers();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
